FILE: src/assert_macros.svh
// Assertion macros for the block decoder checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define BCDEC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// Clocked property, checked through reset as well.
`define BCDEC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error(msg);

`endif

FILE: src/bcdec_pkg.sv
`default_nettype none
package bcdec_pkg;

  localparam int QUEUE_DEPTH  = 2;
  localparam int PIXELS       = 16;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;

  localparam logic [3:0]  LAST_PIX     = 4'd15;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0]  ALPHA_CLEAR  = 8'd0;
  localparam logic [4:0]  MASK5        = 5'h1f;
  localparam logic [5:0]  MASK6        = 6'h3f;

  // reciprocal multipliers, exact over the numerator ranges used
  localparam logic [20:0] DIV3_MUL = 21'd683;   // >> 11, x <= 765
  localparam logic [21:0] DIV7_MUL = 22'd2341;  // >> 14, x <= 1785
  localparam logic [20:0] DIV5_MUL = 21'd1639;  // >> 13, x <= 1275

  // register byte-address word select
  localparam logic REG_ALPHA_MODE = 1'b0;

  typedef enum logic [1:0] {
    AOP_DIV7   = 2'd0,
    AOP_DIV5   = 2'd1,
    AOP_DIRECT = 2'd2
  } alpha_op_t;

  typedef struct packed {
    logic [7:0]  r0;
    logic [7:0]  g0;
    logic [7:0]  b0;
    logic [7:0]  r1;
    logic [7:0]  g1;
    logic [7:0]  b1;
    logic [63:0] ablk;
    logic [31:0] cidx;
    logic        mode;
    logic        agt;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [2:0] w0;
    logic [2:0] w1;
  } cweight_t;

  typedef struct packed {
    alpha_op_t  op;
    logic [2:0] w0;
    logic [2:0] w1;
    logic [7:0] dval;
  } alpha_sel_t;

  function automatic logic [7:0] expand5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // palette weights out of three: c0, c1, two thirds, one third
  function automatic cweight_t color_w(input logic [1:0] ci);
    cweight_t w;
    case (ci)
      2'd0:    w = '{w0: 3'd3, w1: 3'd0};
      2'd1:    w = '{w0: 3'd0, w1: 3'd3};
      2'd2:    w = '{w0: 3'd2, w1: 3'd1};
      2'd3:    w = '{w0: 3'd1, w1: 3'd2};
      default: w = '{w0: 3'd3, w1: 3'd0};
    endcase
    return w;
  endfunction

  // interpolated alpha code k: weights out of 7 (a0 > a1) or 5, or a fixed value
  function automatic alpha_sel_t alpha_code(input logic gt, input logic [2:0] k);
    alpha_sel_t s;
    s.dval = ALPHA_CLEAR;
    if (gt) begin
      s.op = AOP_DIV7;
      case (k)
        3'd0:    begin s.w0 = 3'd7; s.w1 = 3'd0; end
        3'd1:    begin s.w0 = 3'd0; s.w1 = 3'd7; end
        default: begin s.w0 = 3'd0 - k; s.w1 = k - 3'd1; end  // 8-k, k-1
      endcase
    end else begin
      s.op = AOP_DIV5;
      case (k)
        3'd0:    begin s.w0 = 3'd5; s.w1 = 3'd0; end
        3'd1:    begin s.w0 = 3'd0; s.w1 = 3'd5; end
        3'd6:    begin s.op = AOP_DIRECT; s.w0 = 3'd0; s.w1 = 3'd0; end
        3'd7:    begin
          s.op = AOP_DIRECT; s.w0 = 3'd0; s.w1 = 3'd0; s.dval = ALPHA_OPAQUE;
        end
        default: begin s.w0 = 3'd6 - k; s.w1 = k - 3'd1; end
      endcase
    end
    return s;
  endfunction

  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * DIV3_MUL;
    return p[18:11];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * DIV7_MUL;
    return p[21:14];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [20:0] p;
    p = 21'(x) * DIV5_MUL;
    return p[20:13];
  endfunction

endpackage
`default_nettype wire

FILE: src/bcdec_front.sv
`default_nettype none
module bcdec_front (
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [63:0]       in_alpha_block,
  input  wire logic [63:0]       in_color_block,
  input  wire logic              alpha_mode,
  input  wire bcdec_pkg::q_stat_t q_stat,
  output logic                   push,
  output bcdec_pkg::entry_t      entry
);

  logic [15:0] c0;
  logic [15:0] c1;

  assign busy = q_stat.full;
  assign push = start && !q_stat.full;

  assign c0 = in_color_block[15:0];
  assign c1 = in_color_block[31:16];

  // endpoint expansion and alpha table choice, done once per block
  always_comb begin
    entry.r0   = bcdec_pkg::expand5(c0[15:11] & bcdec_pkg::MASK5);
    entry.g0   = bcdec_pkg::expand6(c0[10:5] & bcdec_pkg::MASK6);
    entry.b0   = bcdec_pkg::expand5(c0[4:0] & bcdec_pkg::MASK5);
    entry.r1   = bcdec_pkg::expand5(c1[15:11] & bcdec_pkg::MASK5);
    entry.g1   = bcdec_pkg::expand6(c1[10:5] & bcdec_pkg::MASK6);
    entry.b1   = bcdec_pkg::expand5(c1[4:0] & bcdec_pkg::MASK5);
    entry.ablk = in_alpha_block;
    entry.cidx = in_color_block[63:32];
    entry.mode = alpha_mode;
    entry.agt  = in_alpha_block[7:0] > in_alpha_block[15:8];
  end

endmodule
`default_nettype wire

FILE: src/bcdec_queue.sv
`default_nettype none
module bcdec_queue #(
  parameter int DEPTH = bcdec_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire bcdec_pkg::entry_t wr_entry,
  input  wire logic              pop,
  output bcdec_pkg::entry_t      rd_entry,
  output bcdec_pkg::q_stat_t     q_stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  bcdec_pkg::entry_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign q_stat.full  = (cnt_r == FULL_CNT);
  assign q_stat.empty = (cnt_r == '0);
  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;
  assign rd_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule
`default_nettype wire

FILE: src/bcdec_back.sv
`default_nettype none
module bcdec_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bcdec_pkg::entry_t  head,
  input  wire bcdec_pkg::q_stat_t q_stat,
  output logic                    pop,
  output logic                    out_valid,
  output logic [3:0]              out_pixel_index,
  output logic [7:0]              out_red,
  output logic [7:0]              out_green,
  output logic [7:0]              out_blue,
  output logic [7:0]              out_alpha,
  output logic                    out_last_pixel
);

  logic [3:0]  pix_r, pix_nxt;
  logic        run;

  // stage 1: weighted sums
  logic        s1_valid_r;
  logic [3:0]  s1_idx_r;
  logic        s1_last_r;
  logic [9:0]  s1_rn_r, s1_gn_r, s1_bn_r;
  logic [10:0] s1_an_r;
  bcdec_pkg::alpha_op_t s1_aop_r;
  logic [7:0]  s1_adir_r;

  logic [1:0]  ci;
  logic [5:0]  abit;
  logic [2:0]  ak;
  logic [3:0]  nib;
  bcdec_pkg::cweight_t   cw;
  bcdec_pkg::alpha_sel_t asel;
  logic [9:0]  rn, gn, bn;
  logic [10:0] an;
  bcdec_pkg::alpha_op_t aop;
  logic [7:0]  adir;

  // stage 2: output registers
  logic        o_valid_r;
  logic [3:0]  o_idx_r;
  logic        o_last_r;
  logic [7:0]  o_r_r, o_g_r, o_b_r, o_a_r;
  logic [7:0]  a_q;

  assign run     = !q_stat.empty;
  assign pop     = run && (pix_r == bcdec_pkg::LAST_PIX);
  assign pix_nxt = run ? pix_r + 4'd1 : pix_r;

  assign ci   = head.cidx[{pix_r, 1'b0} +: 2];
  assign abit = 6'd16 + {1'b0, pix_r, 1'b0} + {2'b00, pix_r};
  assign ak   = head.ablk[abit +: 3];
  assign nib  = head.ablk[{pix_r, 2'b00} +: 4];
  assign cw   = bcdec_pkg::color_w(ci);
  assign asel = bcdec_pkg::alpha_code(head.agt, ak);

  always_comb begin
    rn = 10'(11'(cw.w0) * 11'(head.r0) + 11'(cw.w1) * 11'(head.r1));
    gn = 10'(11'(cw.w0) * 11'(head.g0) + 11'(cw.w1) * 11'(head.g1));
    bn = 10'(11'(cw.w0) * 11'(head.b0) + 11'(cw.w1) * 11'(head.b1));
    an = 11'(asel.w0) * 11'(head.ablk[7:0]) + 11'(asel.w1) * 11'(head.ablk[15:8]);
    if (head.mode) begin
      aop  = asel.op;
      adir = asel.dval;
    end else begin
      aop  = bcdec_pkg::AOP_DIRECT;
      adir = {nib, nib};
    end
  end

  always_comb begin
    case (s1_aop_r)
      bcdec_pkg::AOP_DIV7:   a_q = bcdec_pkg::div7(s1_an_r);
      bcdec_pkg::AOP_DIV5:   a_q = bcdec_pkg::div5(s1_an_r);
      bcdec_pkg::AOP_DIRECT: a_q = s1_adir_r;
      default:               a_q = s1_adir_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r      <= '0;
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      pix_r      <= pix_nxt;
      s1_valid_r <= run;
      o_valid_r  <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r  <= pix_r;
    s1_last_r <= (pix_r == bcdec_pkg::LAST_PIX);
    s1_rn_r   <= rn;
    s1_gn_r   <= gn;
    s1_bn_r   <= bn;
    s1_an_r   <= an;
    s1_aop_r  <= aop;
    s1_adir_r <= adir;
    o_idx_r   <= s1_idx_r;
    o_last_r  <= s1_last_r;
    o_r_r     <= bcdec_pkg::div3(s1_rn_r);
    o_g_r     <= bcdec_pkg::div3(s1_gn_r);
    o_b_r     <= bcdec_pkg::div3(s1_bn_r);
    o_a_r     <= a_q;
  end

  assign out_valid       = o_valid_r;
  assign out_pixel_index = o_idx_r;
  assign out_last_pixel  = o_last_r;
  assign out_red         = o_r_r;
  assign out_green       = o_g_r;
  assign out_blue        = o_b_r;
  assign out_alpha       = o_a_r;

endmodule
`default_nettype wire

FILE: src/bc2_bc3_block_decoder_unit.sv
// Channel   Ports                                   Handshake
// block in  in_alpha_block, in_color_block          start / busy, taken when start & !busy
// pixel out out_pixel_index, out_red/green/blue,    out_valid strobe, one cycle, no stall
//           out_alpha, out_last_pixel
// config    psel, penable, pwrite, paddr, pwdata,   APB write on access cycle, pready tied high
//           prdata, pready                          alpha_mode at byte address 0
//
// A block request is queued when taken; its first pixel passes the stage 1 and output registers once the
// back end reaches it, then its sixteen pixels follow at one pixel per cycle.
// Sustained rate is set by the back end's one-pixel-per-cycle pipe, which walks sixteen pixels per block.
// busy is high only while the block queue (QDEPTH entries) is full.
// Synchronous active-low reset empties the queue, clears the strobes, sets alpha_mode to 1.
// Pixel output cannot be held off; results are dropped if the receiver ignores the strobe.
`default_nettype none
module bc2_bc3_block_decoder_unit #(
  parameter int QDEPTH = bcdec_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // block requests
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] in_alpha_block,
  input  wire logic [63:0] in_color_block,
  // pixels
  output logic             out_valid,
  output logic [3:0]       out_pixel_index,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_alpha,
  output logic             out_last_pixel,
  // configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bcdec_pkg::ADDR_W-1:0] paddr,
  input  wire logic [bcdec_pkg::DATA_W-1:0] pwdata,
  output logic      [bcdec_pkg::DATA_W-1:0] prdata,
  output logic                              pready
);

  logic mode_r, mode_nxt;
  logic wr_mode;

  bcdec_pkg::q_stat_t q_stat;
  bcdec_pkg::entry_t  front_entry;
  bcdec_pkg::entry_t  head_entry;
  logic               push;
  logic               pop;

  // config register: word select is paddr[2], one register at word 0
  assign pready  = 1'b1;
  assign wr_mode = psel && penable && pwrite && pready &&
                   (paddr[2] == bcdec_pkg::REG_ALPHA_MODE);
  assign mode_nxt = wr_mode ? pwdata[0] : mode_r;
  assign prdata   = (paddr[2] == bcdec_pkg::REG_ALPHA_MODE) ?
                    {{(bcdec_pkg::DATA_W-1){1'b0}}, mode_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // front: take block, expand endpoints, pick alpha table
  bcdec_front u_front (
    .start          (start),
    .busy           (busy),
    .in_alpha_block (in_alpha_block),
    .in_color_block (in_color_block),
    .alpha_mode     (mode_r),
    .q_stat         (q_stat),
    .push           (push),
    .entry          (front_entry)
  );

  // decoupling queue between front and pixel pipe
  bcdec_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (front_entry),
    .pop      (pop),
    .rd_entry (head_entry),
    .q_stat   (q_stat)
  );

  // back: walks sixteen pixels of the head block, two-stage pipe
  bcdec_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head_entry),
    .q_stat          (q_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_pixel_index (out_pixel_index),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_alpha       (out_alpha),
    .out_last_pixel  (out_last_pixel)
  );

endmodule
`default_nettype wire

FILE: src/bcdec_checker.sv
`default_nettype none
`include "assert_macros.svh"
module bcdec_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [3:0]  out_pixel_index,
  input wire logic        out_last_pixel,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  // pixels of a block come out on consecutive cycles in raster order
  `BCDEC_ASSERT(a_pix_seq, clk, rst_n,
    out_valid && !out_last_pixel |=> out_valid && out_pixel_index == $past(out_pixel_index) + 4'd1,
    "pixel burst broken")

  // after the last pixel, a new burst starts at pixel zero
  `BCDEC_ASSERT(a_new_burst, clk, rst_n,
    out_valid && out_last_pixel |=> !out_valid || out_pixel_index == 4'd0,
    "burst did not restart at pixel zero")

  // queue fills only on a block request
  `BCDEC_ASSERT(a_busy_rise, clk, rst_n, $rose(busy) |-> $past(start), "busy rose without request")

  // written mode reads back
  `BCDEC_ASSERT(a_readback, clk, rst_n,
    psel && penable && pwrite && pready && !paddr[2] |=> paddr[2] || prdata[0] == $past(pwdata[0]),
    "alpha_mode readback mismatch")

  // reset silences the pixel strobe
  `BCDEC_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_valid, "pixel strobe after reset")

endmodule

bind bc2_bc3_block_decoder_unit bcdec_checker u_bcdec_checker (.*);
`default_nettype wire

FILE: verif/bc2_bc3_block_decoder_unit_tb.sv
`timescale 1ns / 1ps

// Block-level bench for the BC2/BC3 block decoder.
// A directed table of blocks and register writes runs first, then three
// random phases (interpolated, explicit, interpolated alpha). Every
// accepted block request queues its sixteen expected pixels. Each out_valid
// strobe pops and checks the oldest one.
module bc2_bc3_block_decoder_unit_tb;

  // register map, byte addresses
  localparam logic [bcdec_pkg::ADDR_W-1:0] ADDR_ALPHA_MODE = 'd0;
  localparam logic [bcdec_pkg::ADDR_W-1:0] ADDR_SPARE      = 'd4;   // no register, dropped

  localparam logic MODE_EXPLICIT = 1'b0;   // DXT3 nibbles
  localparam logic MODE_INTERP   = 1'b1;   // DXT5 codebook, reset value

  localparam logic TYPED     = 1'b1;   // expected pixel typed into the row
  localparam logic PREDICTED = 1'b0;   // expected pixels come from the decoder model

  localparam int WATCHDOG_LIMIT = 2000;   // cycles with no handshake of any kind
  localparam int SETTLE_CYCLES  = 4;      // after last pixel, before a register write
  localparam int TAIL_CYCLES    = 24;     // after last pixel, watching for strays

  typedef enum logic { ROW_BLOCK, ROW_WRITE } row_kind_t;

  typedef struct packed {
    row_kind_t                    kind;
    logic [bcdec_pkg::ADDR_W-1:0] addr;
    logic [31:0]                  wdata;
    logic [63:0]                  ablk;
    logic [63:0]                  cblk;
    logic                         typed;
    logic [7:0]                   r, g, b, a;   // whole-block color when typed
  } row_t;

  typedef struct packed {
    logic [3:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } pixel_t;

  // Directed table. Typed rows decode to one flat color across the block.
  localparam int NUM_ROWS = 18;
  localparam row_t DIRECTED [NUM_ROWS] = '{
    // reset mode is interpolated: a0 == a1 == 0, all indices 0
    '{ROW_BLOCK, ADDR_ALPHA_MODE, 32'h0, 64'h0, 64'h0, TYPED, 8'd0, 8'd0, 8'd0, 8'd0},
    // all ones: a0 == a1, index 7 is opaque; white endpoints
    '{ROW_BLOCK, ADDR_ALPHA_MODE, 32'h0, '1, '1, TYPED, 8'd255, 8'd255, 8'd255, 8'd255},
    // equal alpha endpoints, every index 6 gives the fixed zero; pure red
    '{ROW_BLOCK, ADDR_ALPHA_MODE, 32'h0, 64'hDB6D_B6DB_6DB6_C8C8, 64'h0000_0000_F800_F800,
      TYPED, 8'd255, 8'd0, 8'd0, 8'd0},
    // equal alpha endpoints, every index 7 gives the fixed 255; pure green
    '{ROW_BLOCK, ADDR_ALPHA_MODE, 32'h0, 64'hFFFF_FFFF_FFFF_0A0A, 64'h0000_0000_07E0_07E0,
      TYPED, 8'd0, 8'd255, 8'd0, 8'd255},
    // alpha index 0 picks a0; color index 1 picks c1 (pure blue)
    '{ROW_BLOCK, ADDR_ALPHA_MODE, 32'h0, 64'h0000_0000_0000_4080, 64'h5555_5555_001F_0000,
      TYPED, 8'd0, 8'd0, 8'd255, 8'd128},
    // alpha indices walk 0..7 twice, color indices walk 0..3
    // a0 > a1: six sevenths
    '{ROW_BLOCK, ADDR_ALPHA_MODE, 32'h0, 64'hFAC6_88FA_C688_00FF, 64'hE4E4_E4E4_ABCD_1234,
      PREDICTED, 8'd0, 8'd0, 8'd0, 8'd0},
    // a0 < a1: four fifths plus 0 and 255; c0 < c1 still four colors
    '{ROW_BLOCK, ADDR_ALPHA_MODE, 32'h0, 64'hFAC6_88FA_C688_FF00, 64'hE4E4_E4E4_FFFF_0000,
      PREDICTED, 8'd0, 8'd0, 8'd0, 8'd0},
    // a0 == a1 takes the five-code table; c0 == c1
    '{ROW_BLOCK, ADDR_ALPHA_MODE, 32'h0, 64'hFAC6_88FA_C688_5555, 64'h1B1B_1B1B_8410_8410,
      PREDICTED, 8'd0, 8'd0, 8'd0, 8'd0},
    // a0 just above a1
    '{ROW_BLOCK, ADDR_ALPHA_MODE, 32'h0, 64'hFAC6_88FA_C688_0001, 64'hE4E4_E4E4_0000_FFFF,
      PREDICTED, 8'd0, 8'd0, 8'd0, 8'd0},
    // wide write value, only bit 0 counts: explicit alpha
    '{ROW_WRITE, ADDR_ALPHA_MODE, 32'hFFFF_FFFE, 64'h0, 64'h0,
      PREDICTED, 8'd0, 8'd0, 8'd0, 8'd0},
    '{ROW_BLOCK, ADDR_ALPHA_MODE, 32'h0, 64'h0, 64'h0, TYPED, 8'd0, 8'd0, 8'd0, 8'd0},
    '{ROW_BLOCK, ADDR_ALPHA_MODE, 32'h0, '1, '1, TYPED, 8'd255, 8'd255, 8'd255, 8'd255},
    // nibble ramps, both directions
    '{ROW_BLOCK, ADDR_ALPHA_MODE, 32'h0, 64'hFEDC_BA98_7654_3210, 64'hE4E4_E4E4_F81F_07E0,
      PREDICTED, 8'd0, 8'd0, 8'd0, 8'd0},
    '{ROW_BLOCK, ADDR_ALPHA_MODE, 32'h0, 64'h0123_4567_89AB_CDEF, 64'h1B1B_1B1B_FFE0_001F,
      PREDICTED, 8'd0, 8'd0, 8'd0, 8'd0},
    // write to an unmapped address: mode must stay explicit
    '{ROW_WRITE, ADDR_SPARE, 32'h1, 64'h0, 64'h0, PREDICTED, 8'd0, 8'd0, 8'd0, 8'd0},
    '{ROW_BLOCK, ADDR_ALPHA_MODE, 32'h0, 64'hFFFF_FFFF_FFFF_0000, 64'hAAAA_AAAA_0000_FFFF,
      PREDICTED, 8'd0, 8'd0, 8'd0, 8'd0},
    // back to interpolated alpha
    '{ROW_WRITE, ADDR_ALPHA_MODE, 32'h1, 64'h0, 64'h0, PREDICTED, 8'd0, 8'd0, 8'd0, 8'd0},
    '{ROW_BLOCK, ADDR_ALPHA_MODE, 32'h0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
      PREDICTED, 8'd0, 8'd0, 8'd0, 8'd0}
  };

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [63:0]                   in_alpha_block;
  logic [63:0]                   in_color_block;
  logic                          out_valid;
  logic [3:0]                    out_pixel_index;
  logic [7:0]                    out_red;
  logic [7:0]                    out_green;
  logic [7:0]                    out_blue;
  logic [7:0]                    out_alpha;
  logic                          out_last_pixel;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [bcdec_pkg::ADDR_W-1:0]  paddr;
  logic [bcdec_pkg::DATA_W-1:0]  pwdata;
  logic [bcdec_pkg::DATA_W-1:0]  prdata;
  logic                          pready;

  pixel_t expected_pixels[$];   // pixels owed by accepted block requests, oldest first
  pixel_t want_pixel;
  logic   alpha_mode_copy;      // bench copy of the alpha_mode register
  int     mismatches;
  int     quiet_cycles;

  bc2_bc3_block_decoder_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_alpha_block  (in_alpha_block),
    .in_color_block  (in_color_block),
    .out_valid       (out_valid),
    .out_pixel_index (out_pixel_index),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_alpha       (out_alpha),
    .out_last_pixel  (out_last_pixel),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void queue_pixel(input int p, input int r, input int g, input int b,
                                      input int a);
    expected_pixels.push_back('{index: 4'(p), red: 8'(r), green: 8'(g), blue: 8'(b),
                                alpha: 8'(a), last: (p == bcdec_pkg::PIXELS - 1)});
  endfunction

  // Decoder model: RGB565 endpoints widened by bit replication, four-entry palette
  // with truncated thirds, alpha from nibbles or from the eight-code table.
  function automatic void decode_block(input logic [63:0] ab, input logic [63:0] cb);
    int          ep[2][3];
    int          pal[4][3];
    int          codes[8];
    int          a0, a1, ci, av, r5, g6, b5;
    logic [15:0] word;
    for (int e = 0; e < 2; e++) begin
      word = cb[16*e +: 16];
      r5 = int'(word[15:11]);
      g6 = int'(word[10:5]);
      b5 = int'(word[4:0]);
      ep[e][0] = (r5 << 3) | (r5 >> 2);
      ep[e][1] = (g6 << 2) | (g6 >> 4);
      ep[e][2] = (b5 << 3) | (b5 >> 2);
    end
    for (int c = 0; c < 3; c++) begin
      pal[0][c] = ep[0][c];
      pal[1][c] = ep[1][c];
      pal[2][c] = (2 * ep[0][c] + ep[1][c]) / 3;
      pal[3][c] = (ep[0][c] + 2 * ep[1][c]) / 3;
    end
    a0 = int'(ab[7:0]);
    a1 = int'(ab[15:8]);
    codes[0] = a0;
    codes[1] = a1;
    if (a0 > a1) begin
      for (int k = 1; k < 7; k++) codes[1 + k] = ((7 - k) * a0 + k * a1) / 7;
    end else begin
      for (int k = 1; k < 5; k++) codes[1 + k] = ((5 - k) * a0 + k * a1) / 5;
      codes[6] = 0;
      codes[7] = 255;
    end
    for (int p = 0; p < bcdec_pkg::PIXELS; p++) begin
      ci = int'(cb[32 + 2*p +: 2]);
      if (alpha_mode_copy == MODE_EXPLICIT) av = 17 * int'(ab[4*p +: 4]);
      else av = codes[ab[16 + 3*p +: 3]];
      queue_pixel(p, pal[ci][0], pal[ci][1], pal[ci][2], av);
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Pixels can't be stalled: every strobe is taken at the edge that ends it.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_pixels.size() == 0) begin
        $error("out_pixel_index: no pixel expected, got %0d", out_pixel_index);
        mismatches++;
      end else begin
        want_pixel = expected_pixels.pop_front();
        check_field("out_pixel_index", want_pixel.index, out_pixel_index);
        check_field("out_red", want_pixel.red, out_red);
        check_field("out_green", want_pixel.green, out_green);
        check_field("out_blue", want_pixel.blue, out_blue);
        check_field("out_alpha", want_pixel.alpha, out_alpha);
        check_field("out_last_pixel", want_pixel.last, out_last_pixel);
      end
    end
  end

  // Watchdog: any request, pixel or register access counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Holds start high until a rising edge sees it with busy low.
  task automatic send_block(input logic [63:0] ab, input logic [63:0] cb, input logic typed,
                            input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic [7:0] a);
    start          <= 1'b1;
    in_alpha_block <= ab;
    in_color_block <= cb;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (typed) begin
      for (int p = 0; p < bcdec_pkg::PIXELS; p++) queue_pixel(p, r, g, b, a);
    end else begin
      decode_block(ab, cb);
    end
  endtask

  // Sender idles in bursts now and then; otherwise requests go back to back.
  task automatic maybe_idle(input bit allowed);
    if (allowed && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain_pixels();
    start <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  // Register writes only once the decoder has emptied.
  task automatic write_register(input logic [bcdec_pkg::ADDR_W-1:0] addr,
                                input logic [31:0] value);
    drain_pixels();
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_ALPHA_MODE) alpha_mode_copy = value[0];
  endtask

  task automatic random_phase(input int count, input int quiet_tail);
    logic [63:0] ab, cb;
    for (int i = 0; i < count; i++) begin
      maybe_idle(i < count - quiet_tail);
      ab = {$urandom, $urandom};
      cb = {$urandom, $urandom};
      case ($urandom_range(0, 5))
        0: ab[15:8] = ab[7:0];   // equal alpha endpoints
        1: ab[7:0] = 8'hFF;
        2: ab[7:0] = 8'h00;
        default: ;
      endcase
      if ($urandom_range(0, 4) == 0) cb[31:16] = cb[15:0];   // equal color endpoints
      send_block(ab, cb, PREDICTED, 8'd0, 8'd0, 8'd0, 8'd0);
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_alpha_block  <= '0;
    in_color_block  <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    alpha_mode_copy = MODE_INTERP;
    mismatches      = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        write_register(DIRECTED[i].addr, DIRECTED[i].wdata);
      end else begin
        maybe_idle(1'b1);
        send_block(DIRECTED[i].ablk, DIRECTED[i].cblk, DIRECTED[i].typed,
                   DIRECTED[i].r, DIRECTED[i].g, DIRECTED[i].b, DIRECTED[i].a);
      end
    end

    // random: interpolated, explicit, then interpolated with a gap-free finish
    random_phase(35, 0);
    write_register(ADDR_ALPHA_MODE, 32'(MODE_EXPLICIT));
    random_phase(30, 0);
    write_register(ADDR_ALPHA_MODE, {31'($urandom_range(0, 32'h7FFF_FFFF)), MODE_INTERP});
    random_phase(30, 20);

    drain_pixels();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/bcdec_pkg.sv
src/bcdec_front.sv
src/bcdec_queue.sv
src/bcdec_back.sv
src/bc2_bc3_block_decoder_unit.sv
src/bcdec_checker.sv
verif/bc2_bc3_block_decoder_unit_tb.sv
